/* design/u16u8_pkg.sv */
// Package for the UTF-16 to UTF-8 encoder: range limits, UTF-8 lead bytes,
// the job type that travels from the front end to the serializer, and the
// code point encoding function. No dependencies.
package u16u8_pkg;

  // Default depth of the job queue between front end and serializer.
  localparam int unsigned QDEPTH_DEF = 2;
  // Most bytes one code unit can cause: a flushed high surrogate plus 3 bytes.
  localparam int unsigned MAX_BYTES  = 6;

  // Surrogate ranges.
  localparam logic [15:0] HI_FIRST = 16'hD800;
  localparam logic [15:0] HI_LAST  = 16'hDBFF;
  localparam logic [15:0] LO_FIRST = 16'hDC00;
  localparam logic [15:0] LO_LAST  = 16'hDFFF;

  // Code point limits for the 1, 2 and 3 byte forms.
  localparam logic [20:0] MAX_1B    = 21'h00007F;
  localparam logic [20:0] MAX_2B    = 21'h0007FF;
  localparam logic [20:0] MAX_3B    = 21'h00FFFF;
  localparam logic [20:0] SUPP_BASE = 21'h010000;

  // Lead and continuation byte markers.
  localparam logic [7:0] LEAD2 = 8'b1100_0000;
  localparam logic [7:0] LEAD3 = 8'b1110_0000;
  localparam logic [7:0] LEAD4 = 8'b1111_0000;
  localparam logic [7:0] CONT  = 8'b1000_0000;

  typedef logic [2:0] cnt_t;

  // One encoded code point, first byte in entry 0.
  typedef struct packed {
    logic [3:0][7:0] b;
    cnt_t            n;
  } seq_t;

  // All bytes one code unit causes, first byte in entry 0.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] b;
    cnt_t                      n;
  } job_t;

  // Shortest UTF-8 form of one code point.
  function automatic seq_t encode_cp(input logic [20:0] cp);
    seq_t s;
    s = '0;
    if (cp <= MAX_1B) begin
      s.b[0] = {1'b0, cp[6:0]};
      s.n    = 3'd1;
    end else if (cp <= MAX_2B) begin
      s.b[0] = LEAD2 | {3'b000, cp[10:6]};
      s.b[1] = CONT  | {2'b00, cp[5:0]};
      s.n    = 3'd2;
    end else if (cp <= MAX_3B) begin
      s.b[0] = LEAD3 | {4'b0000, cp[15:12]};
      s.b[1] = CONT  | {2'b00, cp[11:6]};
      s.b[2] = CONT  | {2'b00, cp[5:0]};
      s.n    = 3'd3;
    end else begin
      s.b[0] = LEAD4 | {5'b00000, cp[20:18]};
      s.b[1] = CONT  | {2'b00, cp[17:12]};
      s.b[2] = CONT  | {2'b00, cp[11:6]};
      s.b[3] = CONT  | {2'b00, cp[5:0]};
      s.n    = 3'd4;
    end
    return s;
  endfunction

endpackage

/* design/u16u8_front.sv */
// Front end of the UTF-16 to UTF-8 encoder: classifies each code unit,
// keeps the pending high surrogate and builds the byte job for the queue.
// Depends on u16u8_pkg.
module u16u8_front
  import u16u8_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] code_unit,
  input  logic        string_end,
  output logic        push_valid,
  input  logic        push_ready,
  output job_t        push_job,
  output logic        pend
);

  logic       pend_r, pend_nxt;
  logic [9:0] held_r, held_nxt;
  logic       is_lo, is_hi, pair, accept;
  seq_t       seq_a, seq_b;

  // Classify the incoming unit.
  assign is_lo  = (code_unit >= LO_FIRST) && (code_unit <= LO_LAST);
  assign is_hi  = (code_unit >= HI_FIRST) && (code_unit <= HI_LAST);
  assign pair   = pend_r && is_lo;
  assign accept = in_valid && push_ready;

  // Bytes from the held surrogate: a full pair, or the lone high on its own.
  always_comb begin
    if (pair) begin
      seq_a = encode_cp({1'b0, held_r, code_unit[9:0]} + SUPP_BASE);
    end else begin
      seq_a = encode_cp({5'b00000, HI_FIRST[15:10], held_r});
    end
  end

  // Bytes from the new unit itself; lone lows and held highs give none.
  always_comb begin
    seq_b = '0;
    if (!is_lo && (!is_hi || string_end)) begin
      seq_b = encode_cp({5'b00000, code_unit});
    end
  end

  // Assemble the job in output order.
  always_comb begin
    if (pair) begin
      push_job.b = {16'h0000, seq_a.b};
      push_job.n = 3'd4;
    end else if (pend_r) begin
      push_job.b = {seq_b.b[2:0], seq_a.b[2:0]};
      push_job.n = cnt_t'(3'd3 + seq_b.n);
    end else begin
      push_job.b = {16'h0000, seq_b.b};
      push_job.n = seq_b.n;
    end
  end

  assign in_ready   = push_ready;
  assign push_valid = accept && (push_job.n != 3'd0);
  assign pend       = pend_r;

  // Surrogate hold state, updated on every accepted transaction.
  always_comb begin
    pend_nxt = pend_r;
    held_nxt = held_r;
    if (accept) begin
      pend_nxt = 1'b0;
      held_nxt = '0;
      if (!pair && is_hi && !string_end) begin
        pend_nxt = 1'b1;
        held_nxt = code_unit[9:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      held_r <= '0;
    end else begin
      pend_r <= pend_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

/* design/u16u8_queue.sv */
// Short job queue between the front end and the serializer, built from
// registers with a head and a tail pointer. Depends on u16u8_pkg.
module u16u8_queue
  import u16u8_pkg::*;
#(
  parameter int unsigned DEPTH = QDEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push_valid,
  input  job_t                       push_job,
  output logic                       push_ready,
  output logic                       pop_valid,
  input  logic                       pop,
  output job_t                       pop_job,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_job    = mem_r[rp_r];
  assign count      = cnt_r;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointer and fill count updates, pointers wrap at the depth.
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : PW'(wp_r + 1'b1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : PW'(rp_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Job storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_job;
    end
  end

endmodule

/* design/u16u8_back.sv */
// Serializer of the UTF-16 to UTF-8 encoder, with a registered output (uses
// u16u8_pkg): sends queued jobs one byte per cycle while out_ready is high.
module u16u8_back
  import u16u8_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_valid,
  input  job_t       job,
  output logic       job_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_last
);

  job_t       cur_r, cur_nxt;
  cnt_t       idx_r, idx_nxt;
  logic       busy_r, busy_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] ob_r, ob_nxt;
  logic       ol_r, ol_nxt;
  logic       adv;

  // The output register may be refilled when empty or being taken.
  assign adv = !ov_r || out_ready;

  always_comb begin
    cur_nxt  = cur_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    ov_nxt   = ov_r;
    ob_nxt   = ob_r;
    ol_nxt   = ol_r;
    job_pop  = 1'b0;
    if (adv) begin
      if (busy_r) begin
        // Continue the job in progress.
        ov_nxt   = 1'b1;
        ob_nxt   = cur_r.b[idx_r];
        ol_nxt   = (idx_r == cnt_t'(cur_r.n - 1'b1));
        idx_nxt  = cnt_t'(idx_r + 1'b1);
        busy_nxt = (idx_r != cnt_t'(cur_r.n - 1'b1));
      end else if (job_valid) begin
        // Start a new job and send its first byte straight away.
        job_pop  = 1'b1;
        ov_nxt   = 1'b1;
        ob_nxt   = job.b[0];
        ol_nxt   = (job.n == 3'd1);
        cur_nxt  = job;
        idx_nxt  = 3'd1;
        busy_nxt = (job.n != 3'd1);
      end else begin
        ov_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
      idx_r  <= idx_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    ob_r  <= ob_nxt;
    ol_r  <= ol_nxt;
  end

  assign out_valid = ov_r;
  assign out_byte  = ob_r;
  assign run_last  = ol_r;

endmodule

/* design/utf16_to_utf8_encoder.sv */
// Top level of the UTF-16 to UTF-8 encoder: front end, job queue and
// serializer. Depends on u16u8_pkg, u16u8_front, u16u8_queue, u16u8_back.
//
//  Channel | Direction | tdata              | tlast
//  in_     | input     | [15:0] code_unit   | string_end
//  out_    | output    | [7:0]  out_byte    | run_last
//
// A code unit is taken in every cycle while the job queue has room; it
// yields 0 to 6 bytes. The serializer sends one byte per cycle while
// out_tready is high, so the sustained input rate is bounded by the byte
// count of each unit (1 to 4 for usual text); a unit with none pushes no job.
// The first byte passes through the job queue, then the output register.
// Reset is synchronous and clears the surrogate hold, the queue and output.
// A stalled output fills the queue, after which in_tready goes low.
module utf16_to_utf8_encoder
  import u16u8_pkg::*;
#(
  parameter int unsigned QDEPTH = QDEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] code_unit
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast
);

  localparam int unsigned CW = $clog2(QDEPTH + 1);

  logic          push_valid, push_ready, pop_valid, pop, pend;
  job_t          push_job, pop_job;
  logic [CW-1:0] q_count;

  // Classification and surrogate handling.
  u16u8_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .code_unit  (in_tdata),
    .string_end (in_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pend       (pend)
  );

  // Job queue.
  u16u8_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_job    (pop_job),
    .count      (q_count)
  );

  // Byte serializer.
  u16u8_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (pop_valid),
    .job       (pop_job),
    .job_pop   (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .run_last  (out_tlast)
  );

  // The end of a string never leaves a surrogate held.
  a_end_clears_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !pend)
    else $error("surrogate still held after end of string");

  // The queue fill count never passes its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CW'(QDEPTH))
    else $error("job queue count beyond depth");

  // A plain unit with nothing held always produces output work.
  a_plain_makes_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !pend &&
    ((in_tdata < HI_FIRST) || (in_tdata > LO_LAST))
    |=> (q_count != '0) || out_tvalid)
    else $error("plain code unit produced no bytes");

endmodule
